>>> sv/smtb_pkg.sv
package smtb_pkg;

    // Defaults for the top-level parameters
    localparam int VERTICES_DEF  = 1024;
    localparam int POS_WIDTH_DEF = 32;

    // Fixed field widths of the stream items
    localparam int OP_W     = 2;
    localparam int INDEX_W  = 10;
    localparam int VALUE_W  = 32;
    localparam int WEIGHT_W = 17;
    localparam int COMP_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 17;

    // Blend generation tag kept per vertex; zero never matches a live tag
    localparam int EPOCH_W = 8;

    // Rounded product delta*weight/65536 is 34 bits signed
    localparam int PROD_W   = VALUE_W + WEIGHT_W + 1;
    localparam int SCALED_W = PROD_W - 16;

    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_THRESHOLD  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COMPONENTS_IN_USE = 1'b1;

    localparam logic [WEIGHT_W-1:0] THRESHOLD_RESET = 17'd7;
    localparam logic [COMP_W-1:0]   COMPONENTS_RESET = 2'd3;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_BEGIN = 2'd1,
        OP_ADD   = 2'd2,
        OP_READ  = 2'd3
    } smtb_op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_FINISH
    } smtb_state_t;

    typedef struct packed {
        logic capture;
        logic commit;
        logic clear_en;
    } smtb_cmd_t;

    typedef struct packed {
        logic out_free;
        logic clear_last;
        logic begin_wrap;
    } smtb_status_t;

endpackage

>>> sv/smtb_ctrl.sv
module smtb_ctrl
    import smtb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  smtb_status_t status,
    output logic         ready,
    output smtb_cmd_t    cmd
);

    smtb_state_t state_reg;
    smtb_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = status.begin_wrap ? ST_CLEAR : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        ready        = 1'b0;
        cmd.capture  = 1'b0;
        cmd.commit   = 1'b0;
        cmd.clear_en = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_en = 1'b1;
            end
            ST_IDLE:
            begin
                ready       = 1'b1;
                cmd.capture = in_valid;
            end
            ST_FINISH:
            begin
                cmd.commit = status.out_free;
            end
            default:
            begin
                ready = 1'b0;
            end
        endcase
    end

endmodule

>>> sv/smtb_dp.sv
module smtb_dp
    import smtb_pkg::*;
#(
    parameter int VERTICES  = VERTICES_DEF,
    parameter int POS_WIDTH = POS_WIDTH_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  smtb_cmd_t                   cmd,
    output smtb_status_t                status,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,
    input  logic [OP_W-1:0]             operation,
    input  logic [INDEX_W-1:0]          vertex_index,
    input  logic signed [VALUE_W-1:0]   value_x,
    input  logic signed [VALUE_W-1:0]   value_y,
    input  logic signed [VALUE_W-1:0]   value_z,
    input  logic [WEIGHT_W-1:0]         weight,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic signed [VALUE_W-1:0]   out_x,
    output logic signed [VALUE_W-1:0]   out_y,
    output logic signed [VALUE_W-1:0]   out_z,
    output logic                        saturated
);

    localparam int AW    = $clog2(VERTICES);
    localparam int EXT_W = (POS_WIDTH > VALUE_W) ? POS_WIDTH : VALUE_W;
    localparam int SUM_W = ((POS_WIDTH > SCALED_W) ? POS_WIDTH : SCALED_W) + 1;
    localparam int ROW_W = 3 * POS_WIDTH;

    localparam logic signed [EXT_W-1:0] EXT_MAX =
        {{(EXT_W - POS_WIDTH + 1){1'b0}}, {(POS_WIDTH - 1){1'b1}}};
    localparam logic signed [EXT_W-1:0] EXT_MIN =
        {{(EXT_W - POS_WIDTH + 1){1'b1}}, {(POS_WIDTH - 1){1'b0}}};
    localparam logic signed [SUM_W-1:0] SUM_MAX =
        {{(SUM_W - POS_WIDTH + 1){1'b0}}, {(POS_WIDTH - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN =
        {{(SUM_W - POS_WIDTH + 1){1'b1}}, {(POS_WIDTH - 1){1'b0}}};
    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(32768);

    // Configuration
    logic [WEIGHT_W-1:0] thr_reg;
    logic [COMP_W-1:0]   comp_reg;

    // Held item
    smtb_op_t                  op_reg;
    logic                      ok_reg;
    logic [AW-1:0]             addr_reg;
    logic signed [VALUE_W-1:0] val_reg [3];
    logic [WEIGHT_W-1:0]       w_reg;

    // Products, registered
    logic signed [PROD_W-1:0]  prod_reg  [3];
    logic signed [PROD_W-1:0]  prod_next [3];

    // Memories and their registered read data
    logic [ROW_W-1:0]   base_mem  [VERTICES];
    logic [ROW_W-1:0]   blend_mem [VERTICES];
    logic [EPOCH_W-1:0] mark_mem  [VERTICES];
    logic [ROW_W-1:0]   base_q_reg;
    logic [ROW_W-1:0]   blend_q_reg;
    logic [EPOCH_W-1:0] mark_q_reg;

    // Generation tag and clearing sweep
    logic [EPOCH_W-1:0] epoch_reg;
    logic [AW-1:0]      clr_cnt_reg;

    // Output register
    logic                      out_valid_reg;
    logic signed [VALUE_W-1:0] out_reg [3];
    logic                      sat_reg;

    // Commit-stage datapath
    logic signed [POS_WIDTH-1:0] cur_c   [3];
    logic signed [POS_WIDTH-1:0] base_c  [3];
    logic signed [POS_WIDTH-1:0] new_c   [3];
    logic signed [POS_WIDTH-1:0] load_c  [3];
    logic signed [SCALED_W-1:0]  scaled_c[3];
    logic signed [SUM_W-1:0]     sum_c   [3];
    logic signed [EXT_W-1:0]     ext_c   [3];
    logic [2:0]                  hit_c;
    logic                        is_blended;
    logic                        add_hit;
    logic [ROW_W-1:0]            new_row;
    logic [ROW_W-1:0]            load_row;
    logic                        mark_we;
    logic [AW-1:0]               mark_addr;
    logic [EPOCH_W-1:0]          mark_wdata;

    assign status.out_free   = !out_valid_reg || out_ready;
    assign status.clear_last = (clr_cnt_reg == AW'(VERTICES - 1));
    assign status.begin_wrap = (op_reg == OP_BEGIN) && (epoch_reg == '1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= THRESHOLD_RESET;
            comp_reg <= COMPONENTS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WEIGHT_THRESHOLD:  thr_reg  <= cfg_data[WEIGHT_W-1:0];
                CFG_COMPONENTS_IN_USE: comp_reg <= cfg_data[COMP_W-1:0];
                default:               thr_reg  <= thr_reg;
            endcase
        end
    end

    // Capture the item
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg     <= smtb_op_t'(operation);
            ok_reg     <= ({7'd0, vertex_index} < 17'(VERTICES));
            addr_reg   <= AW'(vertex_index);
            val_reg[0] <= value_x;
            val_reg[1] <= value_y;
            val_reg[2] <= value_z;
            w_reg      <= weight;
        end
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            prod_next[c] = PROD_W'(val_reg[c]) * PROD_W'($signed({1'b0, w_reg}));
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
        begin
            prod_reg[c] <= prod_next[c];
        end
    end

    // Memories: registered read at the held address
    always_ff @(posedge clk)
    begin
        if (cmd.commit && ok_reg && (op_reg == OP_LOAD))
        begin
            base_mem[addr_reg] <= load_row;
        end
        base_q_reg <= base_mem[addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && ok_reg && (op_reg == OP_ADD) && (w_reg >= thr_reg))
        begin
            blend_mem[addr_reg] <= new_row;
        end
        blend_q_reg <= blend_mem[addr_reg];
    end

    always_comb
    begin
        mark_we    = cmd.clear_en
                     || (cmd.commit && ok_reg && (op_reg == OP_ADD) && (w_reg >= thr_reg));
        mark_addr  = cmd.clear_en ? clr_cnt_reg : addr_reg;
        mark_wdata = cmd.clear_en ? '0 : epoch_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mark_we)
        begin
            mark_mem[mark_addr] <= mark_wdata;
        end
        mark_q_reg <= mark_mem[addr_reg];
    end

    // Blend arithmetic for the commit step
    always_comb
    begin
        is_blended = (mark_q_reg == epoch_reg);
        for (int c = 0; c < 3; c++)
        begin
            base_c[c]   = base_q_reg[c*POS_WIDTH +: POS_WIDTH];
            cur_c[c]    = is_blended ? blend_q_reg[c*POS_WIDTH +: POS_WIDTH] : base_c[c];
            scaled_c[c] = SCALED_W'((prod_reg[c] + ROUND_HALF) >>> 16);
            sum_c[c]    = SUM_W'(cur_c[c]) + SUM_W'(scaled_c[c]);
            hit_c[c]    = 1'b0;
            new_c[c]    = cur_c[c];
            if (comp_reg > 2'(c))
            begin
                if (sum_c[c] > SUM_MAX)
                begin
                    new_c[c] = POS_WIDTH'(SUM_MAX);
                    hit_c[c] = 1'b1;
                end
                else if (sum_c[c] < SUM_MIN)
                begin
                    new_c[c] = POS_WIDTH'(SUM_MIN);
                    hit_c[c] = 1'b1;
                end
                else
                begin
                    new_c[c] = POS_WIDTH'(sum_c[c]);
                end
            end
            ext_c[c] = EXT_W'(val_reg[c]);
            if (ext_c[c] > EXT_MAX)
            begin
                load_c[c] = POS_WIDTH'(EXT_MAX);
            end
            else if (ext_c[c] < EXT_MIN)
            begin
                load_c[c] = POS_WIDTH'(EXT_MIN);
            end
            else
            begin
                load_c[c] = POS_WIDTH'(ext_c[c]);
            end
            new_row[c*POS_WIDTH +: POS_WIDTH]  = new_c[c];
            load_row[c*POS_WIDTH +: POS_WIDTH] = load_c[c];
        end
        add_hit = |hit_c;
    end

    // Generation tag and clearing sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epoch_reg   <= EPOCH_W'(1);
            clr_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.commit && (op_reg == OP_BEGIN))
            begin
                epoch_reg <= (epoch_reg == '1) ? EPOCH_W'(1) : epoch_reg + EPOCH_W'(1);
            end
            if (cmd.clear_en)
            begin
                clr_cnt_reg <= status.clear_last ? '0 : clr_cnt_reg + AW'(1);
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            for (int c = 0; c < 3; c++)
            begin
                out_reg[c] <= (ok_reg && (op_reg == OP_READ))
                              ? VALUE_W'(EXT_W'(cur_c[c])) : '0;
            end
            sat_reg <= ok_reg && (op_reg == OP_ADD) && (w_reg >= thr_reg) && add_hit;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_x     = out_reg[0];
    assign out_y     = out_reg[1];
    assign out_z     = out_reg[2];
    assign saturated = sat_reg;

    a_no_clear_at_commit: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.clear_en && cmd.commit))
        else $error("clearing sweep overlaps a commit");

    a_epoch_live: assert property (@(posedge clk) disable iff (!rst_n)
        epoch_reg != '0)
        else $error("blend tag reached the cleared value");

    a_commit_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("commit did not present a result");

    a_no_capture_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> !cmd.clear_en && !cmd.commit)
        else $error("item captured while another is in flight");

endmodule

>>> sv/sparse_morph_target_blend_unit.sv
// Items are taken one at a time: the memory read, the multiply stage and the commit
//   stage run in turn, the commit waits for a free output register, and the next
//   item is accepted while the result waits.
// Reset: control and configuration clear at once; a clearing pass over all VERTICES
//   per-vertex blend tags resets them; every 255th begin item repeats that pass.
module sparse_morph_target_blend_unit
    import smtb_pkg::*;
#(
    parameter int VERTICES  = VERTICES_DEF,
    parameter int POS_WIDTH = POS_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // operation, vertex_index, value_x, value_y, value_z, weight, zero fill
    input  logic [127:0]          s_tdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // out_x, out_y, out_z, saturated, zero fill
    output logic [103:0]          m_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    smtb_cmd_t    cmd;
    smtb_status_t status;

    logic signed [VALUE_W-1:0] out_x;
    logic signed [VALUE_W-1:0] out_y;
    logic signed [VALUE_W-1:0] out_z;
    logic                      saturated;

    // Controller: sequences clear sweep, read, multiply and commit
    smtb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .status   (status),
        .ready    (s_tready),
        .cmd      (cmd)
    );

    // Datapath: vertex memories, blend arithmetic and the output register
    smtb_dp #(
        .VERTICES  (VERTICES),
        .POS_WIDTH (POS_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .operation    (s_tdata[1:0]),
        .vertex_index (s_tdata[11:2]),
        .value_x      (s_tdata[43:12]),
        .value_y      (s_tdata[75:44]),
        .value_z      (s_tdata[107:76]),
        .weight       (s_tdata[124:108]),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .out_x        (out_x),
        .out_y        (out_y),
        .out_z        (out_z),
        .saturated    (saturated)
    );

    // Pack the result beat, lowest field first
    assign m_tdata = {7'd0, saturated, out_z, out_y, out_x};

endmodule
